// ===== rtl/wsfr_pkg.sv =====
`timescale 1ns / 1ps

package wsfr_pkg;

    localparam int LENGTH_BITS_DEF = 64;
    localparam int CMD_DEPTH       = 4;
    localparam int RES_DEPTH       = 4;

    localparam logic [15:0] LIMIT_RESET = 16'd1024;
    localparam logic [6:0]  LEN_EXT16   = 7'd126;
    localparam logic [6:0]  LEN_EXT64   = 7'd127;
    localparam logic [3:0]  OPC_PING    = 4'h9;
    localparam logic [7:0]  PONG_BYTE0  = 8'h8A;
    localparam logic [7:0]  PONG_BYTE1  = 8'h00;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_REPLY   = 2'd2
    } kind_t;

    // One classified input word: an optional payload byte and an optional frame end
    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic       done;
        logic       trunc;
        logic [3:0] opcode;
        logic       fin;
    } cmd_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       fin;
        logic       trunc;
        logic       last;
    } res_t;

endpackage

// ===== rtl/wsfr_fifo.sv =====
`timescale 1ns / 1ps

module wsfr_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/wsfr_front.sv =====
`timescale 1ns / 1ps

module wsfr_front
    import wsfr_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  in_data,
    input  logic [15:0] limit,
    output logic        cmd_valid,
    output cmd_t        cmd
);

    typedef enum logic [4:0] {
        PH_HDR = 5'b00001,
        PH_LEN = 5'b00010,
        PH_EXT = 5'b00100,
        PH_KEY = 5'b01000,
        PH_PAY = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   fin_reg, fin_next;
    logic                   mask_reg, mask_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [31:0]            key_reg, key_next;
    logic [LENGTH_BITS-1:0] idx_reg, idx_next;

    logic [LENGTH_BITS-1:0] limit_ext;
    logic [LENGTH_BITS-1:0] idx_inc;
    logic [7:0]             key_byte;
    logic                   known;
    logic                   finish;

    assign limit_ext = LENGTH_BITS'(limit);
    assign idx_inc   = idx_reg + 1'b1;

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        mask_next   = mask_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        known       = 1'b0;
        finish      = 1'b0;
        cmd.has_data = 1'b0;
        cmd.data     = '0;
        cmd.done     = 1'b0;
        cmd.trunc    = 1'b0;
        cmd.opcode   = opcode_reg;
        cmd.fin      = fin_reg;

        if (in_valid)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    mask_next = in_data[7];
                    key_next  = '0;
                    idx_next  = '0;
                    if (in_data[6:0] == LEN_EXT16)
                    begin
                        len_next   = '0;
                        cnt_next   = 3'd1;
                        phase_next = PH_EXT;
                    end
                    else if (in_data[6:0] == LEN_EXT64)
                    begin
                        len_next   = '0;
                        cnt_next   = 3'd7;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        len_next = LENGTH_BITS'(in_data[6:0]);
                        known    = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    // shift in big endian, upper bits fall off
                    len_next = {len_reg[LENGTH_BITS-9:0], in_data};
                    if (cnt_reg == '0)
                    begin
                        known = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], in_data};
                    if (cnt_reg == '0)
                    begin
                        phase_next = PH_PAY;
                        finish     = (len_reg == '0);
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                PH_PAY:
                begin
                    if (idx_reg < limit_ext)
                    begin
                        cmd.has_data = 1'b1;
                        cmd.data     = in_data ^ key_byte;
                    end
                    idx_next = idx_inc;
                    if (idx_inc >= len_reg)
                    begin
                        finish    = 1'b1;
                        cmd.trunc = (len_reg > limit_ext);
                    end
                end
                default:
                begin
                    fin_next    = in_data[7];
                    opcode_next = in_data[3:0];
                    phase_next  = PH_LEN;
                end
            endcase

            if (known)
            begin
                if (mask_next)
                begin
                    cnt_next   = 3'd3;
                    phase_next = PH_KEY;
                end
                else
                begin
                    phase_next = PH_PAY;
                    finish     = (len_next == '0);
                end
            end

            if (finish)
            begin
                cmd.done   = 1'b1;
                phase_next = PH_HDR;
                idx_next   = '0;
            end
        end
    end

    assign cmd_valid = cmd.has_data || cmd.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR;
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            mask_reg   <= 1'b0;
            cnt_reg    <= '0;
            len_reg    <= '0;
            key_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            mask_reg   <= mask_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

// ===== rtl/wsfr_back.sv =====
`timescale 1ns / 1ps

module wsfr_back
    import wsfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_empty,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_valid,
    output res_t res
);

    typedef enum logic [3:0] {
        ST_FIRST   = 4'b0001,
        ST_DONE    = 4'b0010,
        ST_PONG_HI = 4'b0100,
        ST_PONG_LO = 4'b1000
    } step_t;

    step_t step_reg, step_next;
    logic  go;
    logic  ping;

    assign go   = !cmd_empty && !res_full;
    assign ping = cmd.done && (cmd.opcode == OPC_PING);

    always_comb
    begin
        step_next  = step_reg;
        cmd_pop    = 1'b0;
        res.kind   = KIND_DONE;
        res.data   = '0;
        res.opcode = cmd.opcode;
        res.fin    = cmd.fin;
        res.trunc  = cmd.trunc;
        res.last   = 1'b0;

        case (step_reg)
            ST_FIRST:
            begin
                if (cmd.has_data)
                begin
                    res.kind  = KIND_PAYLOAD;
                    res.data  = cmd.data;
                    res.trunc = 1'b0;
                    res.last  = !cmd.done;
                    step_next = cmd.done ? ST_DONE : ST_FIRST;
                end
                else
                begin
                    res.last  = !ping;
                    step_next = ping ? ST_PONG_HI : ST_FIRST;
                end
            end
            ST_DONE:
            begin
                res.last  = !ping;
                step_next = ping ? ST_PONG_HI : ST_FIRST;
            end
            ST_PONG_HI:
            begin
                res.kind  = KIND_REPLY;
                res.data  = PONG_BYTE0;
                step_next = ST_PONG_LO;
            end
            ST_PONG_LO:
            begin
                res.kind  = KIND_REPLY;
                res.data  = PONG_BYTE1;
                res.last  = 1'b1;
                step_next = ST_FIRST;
            end
            default:
            begin
                step_next = ST_FIRST;
            end
        endcase

        // release the command with its last result
        cmd_pop = go && res.last;
        if (!go)
        begin
            step_next = step_reg;
        end
    end

    assign res_valid = go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_FIRST;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/websocket_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// The first result word of an input word passes the command queue and then the result queue
// before it reaches the result ports, and may wait in either. Throughput: one received byte
// per cycle; full rises only while the command queue is full. Results leave at one per cycle
// while pop is high and empty is low; a ping frame's final byte expands into up to four results.
// Reset (rst_n, async, active low): parser returns to the first header byte, both queues
// empty, payload keep limit back to 1024.

module websocket_frame_receiver_top
    import wsfr_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // received byte stream
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    // result stream
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [3:0]  frame_opcode,
    output logic        final_fragment,
    output logic        was_truncated,
    output logic        last_of_run,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ADDR_KEEP_LIMIT = 2'd0;
    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

    logic [15:0]      limit_reg, limit_next;
    logic             accept;
    logic             cmd_valid;
    cmd_t             cmd_in;
    logic [CMD_W-1:0] cmd_rd_data;
    cmd_t             cmd_head;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             res_full;
    logic             res_valid;
    res_t             res_in;
    logic [RES_W-1:0] res_rd_data;
    res_t             res_head;

    // Configuration: zero wait states, single keep-limit register
    assign pready = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && (paddr == ADDR_KEEP_LIMIT))
        begin
            limit_next = pwdata[15:0];
        end
    end

    assign prdata = (paddr == ADDR_KEEP_LIMIT) ? {16'b0, limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // Front end: parse one word per cycle; hold input off while the command queue is full
    assign accept = push && !full;

    wsfr_front
    #(
        .LENGTH_BITS(LENGTH_BITS)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_data   (rx_byte),
        .limit     (limit_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_in)
    );

    // Command queue decouples parsing from result expansion
    wsfr_fifo
    #(
        .WIDTH(CMD_W),
        .DEPTH(CMD_DEPTH)
    )
    u_cmd_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    assign cmd_head = cmd_t'(cmd_rd_data);

    // Back end: expand each command into payload, frame-done and pong words
    wsfr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_valid (res_valid),
        .res       (res_in)
    );

    // Result queue: a stalled consumer fills it, which halts the back end and can block the parser
    wsfr_fifo
    #(
        .WIDTH(RES_W),
        .DEPTH(RES_DEPTH)
    )
    u_res_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign res_head       = res_t'(res_rd_data);
    assign kind           = res_head.kind;
    assign data_byte      = res_head.data;
    assign frame_opcode   = res_head.opcode;
    assign final_fragment = res_head.fin;
    assign was_truncated  = res_head.trunc;
    assign last_of_run    = res_head.last;

endmodule
